>>> rtl/lgpc_pkg.sv
package lgpc_pkg;

  typedef struct packed {
    logic [1:0]         func;
    logic [15:0]        p_start;
    logic signed [31:0] t_ref;
    logic signed [31:0] speed;
    logic signed [31:0] t_eval;
    logic signed [31:0] space_shift;
    logic signed [31:0] time_offset;
    logic               last_dim;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] value;
    logic               error;
    logic               last_out;
  } out_item_t;

  // classified request as it sits in the queue
  typedef struct packed {
    in_item_t           item;
    logic               early_err;
    logic signed [32:0] dt0;
  } q_entry_t;

  localparam logic [1:0] FUNC_VALUE = 2'd0;
  localparam logic [1:0] FUNC_DERIV = 2'd1;
  localparam logic [1:0] FUNC_PAR   = 2'd2;
  localparam logic [1:0] FUNC_NONE  = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [3:0]  EXP_TERMS = 4'd12;

  // floor(2^33 / k), series divisor by reciprocal
  function automatic logic [33:0] recip(input logic [3:0] k);
    logic [33:0] r;
    case (k)
      4'd1:    r = 34'd8589934592;
      4'd2:    r = 34'd4294967296;
      4'd3:    r = 34'd2863311530;
      4'd4:    r = 34'd2147483648;
      4'd5:    r = 34'd1717986918;
      4'd6:    r = 34'd1431655765;
      4'd7:    r = 34'd1227133513;
      4'd8:    r = 34'd1073741824;
      4'd9:    r = 34'd954437176;
      4'd10:   r = 34'd858993459;
      4'd11:   r = 34'd780903144;
      4'd12:   r = 34'd715827882;
      default: r = 34'd0;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/lgpc_div.sv
module lgpc_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [63:0] divisor,
  output logic        done,
  output logic [63:0] quot,
  output logic [63:0] rem
);

  logic [63:0] q_r;
  logic [63:0] r_r;
  logic [63:0] dvs_r;
  logic [5:0]  cnt_r;
  logic        active_r;
  logic        done_r;
  logic [64:0] sh;
  logic        fit;

  assign sh  = {r_r, q_r[63]};
  assign fit = sh >= {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      cnt_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        active_r <= 1'b1;
        cnt_r    <= 6'd63;
      end else if (active_r) begin
        cnt_r <= cnt_r - 6'd1;
        if (cnt_r == 6'd0) begin
          active_r <= 1'b0;
          done_r   <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      r_r   <= '0;
      dvs_r <= divisor;
    end else if (active_r) begin
      r_r <= fit ? 64'(sh - {1'b0, dvs_r}) : sh[63:0];
      q_r <= {q_r[62:0], fit};
    end
  end

  assign done = done_r;
  assign quot = q_r;
  assign rem  = r_r;

endmodule

>>> rtl/lgpc_fifo.sv
module lgpc_fifo (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  lgpc_pkg::q_entry_t       wdata,
  input  logic                     pop,
  output lgpc_pkg::q_entry_t       rdata,
  output logic                     full,
  output logic                     empty,
  output logic [lgpc_pkg::QCNT_W-1:0] count
);

  lgpc_pkg::q_entry_t mem [lgpc_pkg::QDEPTH];
  logic [lgpc_pkg::QPTR_W-1:0] wr_r;
  logic [lgpc_pkg::QPTR_W-1:0] rd_r;
  logic [lgpc_pkg::QCNT_W-1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_r + 1'b1;
      if (pop)  rd_r <= rd_r + 1'b1;
      if (push && !pop)      cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_r] <= wdata;
  end

  assign rdata = mem[rd_r];
  assign full  = cnt_r == lgpc_pkg::QCNT_W'(lgpc_pkg::QDEPTH);
  assign empty = cnt_r == '0;
  assign count = cnt_r;

endmodule

>>> rtl/lgpc_front.sv
module lgpc_front (
  input  logic                 start,
  input  lgpc_pkg::in_item_t   in_data,
  input  logic                 q_full,
  output logic                 busy,
  output logic                 push,
  output lgpc_pkg::q_entry_t   entry
);

  logic signed [32:0] dt_eval;

  assign dt_eval = 33'(in_data.t_eval) - 33'(in_data.t_ref);

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    entry.item      = in_data;
    entry.early_err = (in_data.func == lgpc_pkg::FUNC_NONE) || (in_data.p_start == '0);
    // parallel coordinate starts with the derivative at t_ref + offset
    entry.dt0       = (in_data.func == lgpc_pkg::FUNC_PAR) ? 33'(in_data.time_offset) : dt_eval;
  end

endmodule

>>> rtl/lgpc_back.sv
module lgpc_back #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  lgpc_pkg::q_entry_t   q_data,
  output logic                 q_pop,
  output logic                 out_valid,
  output lgpc_pkg::out_item_t  out_data
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_QI    = 5'd1;
  localparam logic [4:0] S_DIVA  = 5'd2;
  localparam logic [4:0] S_DIVAW = 5'd3;
  localparam logic [4:0] S_CORE  = 5'd4;
  localparam logic [4:0] S_M1    = 5'd5;
  localparam logic [4:0] S_M2    = 5'd6;
  localparam logic [4:0] S_M3    = 5'd7;
  localparam logic [4:0] S_M4    = 5'd8;
  localparam logic [4:0] S_M5    = 5'd9;
  localparam logic [4:0] S_H1    = 5'd10;
  localparam logic [4:0] S_H2    = 5'd11;
  localparam logic [4:0] S_H3    = 5'd12;
  localparam logic [4:0] S_EX    = 5'd13;
  localparam logic [4:0] S_EM    = 5'd14;
  localparam logic [4:0] S_DEN   = 5'd15;
  localparam logic [4:0] S_VS    = 5'd16;
  localparam logic [4:0] S_VW    = 5'd17;
  localparam logic [4:0] S_DM    = 5'd18;
  localparam logic [4:0] S_DS1   = 5'd19;
  localparam logic [4:0] S_DW1   = 5'd20;
  localparam logic [4:0] S_DS2   = 5'd21;
  localparam logic [4:0] S_DW2   = 5'd22;
  localparam logic [4:0] S_DD    = 5'd23;
  localparam logic [4:0] S_QS    = 5'd24;
  localparam logic [4:0] S_QW    = 5'd25;
  localparam logic [4:0] S_CSUM  = 5'd26;
  localparam logic [4:0] S_FIN   = 5'd27;
  localparam logic [4:0] S_DT    = 5'd28;
  localparam logic [4:0] S_DTW   = 5'd29;

  localparam logic [63:0] CAP      = 64'd32 << FRAC_BITS;
  localparam logic [32:0] ONE_Q32  = 33'h1_0000_0000;
  localparam logic [31:0] POS_LIM  = 32'h7FFF_FFFF;
  localparam logic [63:0] NEG_LIM  = 64'h8000_0000;

  logic [4:0]  state_r, state_nxt;
  lgpc_pkg::q_entry_t ent_r;
  logic [63:0] am_r;
  logic signed [32:0] dt_r;
  logic [64:0] lo_r;
  logic [29:0] x24_r;
  logic [6:0]  n_r;
  logic [31:0] u_r;
  logic [32:0] acc_r;
  logic [3:0]  k_r;
  logic [31:0] a_r;
  logic [32:0] ex_r;
  logic        xpos_r;
  logic [33:0] den_r;
  logic [31:0] num_r;
  logic [63:0] m_r;
  logic        err_r;
  logic        phase_r;
  logic [31:0] val_r;
  logic signed [32:0] quo_r;
  logic [31:0] dmag_r;
  logic        dneg_r;
  logic        out_valid_r;
  lgpc_pkg::out_item_t out_data_r;
  logic [67:0] prod_r;

  logic [33:0] mul_a, mul_b;
  logic        div_start;
  logic [63:0] div_dvd, div_dvs;
  logic        div_done;
  logic [63:0] div_quot, div_rem;

  logic [15:0] p;
  logic [16:0] b;
  logic        vneg, wneg, dtneg, is_deriv;
  logic [31:0] vm, wm;
  logic [32:0] dm;
  logic [96:0] full;
  logic [63:0] xm, xsh;
  logic [31:0] q0;
  logic [35:0] remk;
  logic [31:0] qh;
  logic [32:0] pe;
  logic [31:0] dsat;
  logic        dovf;
  logic [31:0] qsat;
  logic        qneg, qovf;
  logic signed [34:0] csum;
  logic signed [31:0] c32;
  logic        covf;

  assign p     = ent_r.item.p_start;
  assign b     = 17'h10000 - 17'(p);
  assign vneg  = ent_r.item.speed[31];
  assign wneg  = ent_r.item.space_shift[31];
  assign vm    = vneg ? 32'(-ent_r.item.speed) : 32'(ent_r.item.speed);
  assign wm    = wneg ? 32'(-ent_r.item.space_shift) : 32'(ent_r.item.space_shift);
  assign dtneg = dt_r[32];
  assign dm    = dtneg ? 33'(-dt_r) : 33'(dt_r);
  assign is_deriv = (ent_r.item.func == lgpc_pkg::FUNC_DERIV) ||
                    ((ent_r.item.func == lgpc_pkg::FUNC_PAR) && !phase_r);

  // |x| = am * |dt| >> FRAC_BITS, capped at 32.0
  assign full = {prod_r[64:0], 32'd0} + {32'd0, lo_r};
  assign xsh  = full[63:0] >> FRAC_BITS;
  assign xm   = ((|full[96:64]) || (xsh > CAP)) ? CAP : xsh;

  // series step: divide by k through reciprocal, one correction
  assign q0   = prod_r[64:33];
  assign remk = {4'd0, a_r} - (36'(q0) * 36'(k_r));
  assign qh   = (remk >= 36'(k_r)) ? q0 + 32'd1 : q0;

  assign pe = prod_r[48:16];

  // derivative magnitude, saturated by sign of speed
  always_comb begin
    if (vneg) begin
      dovf = m_r > NEG_LIM;
      dsat = dovf ? 32'h8000_0000 : m_r[31:0];
    end else begin
      dovf = m_r > {32'd0, POS_LIM};
      dsat = dovf ? POS_LIM : m_r[31:0];
    end
  end

  assign qneg = wneg ^ dneg_r;
  always_comb begin
    if (qneg) begin
      qovf = div_quot > NEG_LIM;
      qsat = qovf ? 32'h8000_0000 : div_quot[31:0];
    end else begin
      qovf = div_quot > {32'd0, POS_LIM};
      qsat = qovf ? POS_LIM : div_quot[31:0];
    end
  end

  assign csum = 35'(quo_r) + 35'(ent_r.item.time_offset) + 35'(ent_r.item.t_eval);
  always_comb begin
    covf = 1'b0;
    c32  = csum[31:0];
    if (csum > 35'sd2147483647) begin
      covf = 1'b1;
      c32  = 32'sh7FFF_FFFF;
    end else if (csum < -35'sd2147483648) begin
      covf = 1'b1;
      c32  = 32'sh8000_0000;
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_QI:    begin mul_a = 34'(p);             mul_b = 34'(b); end
      S_CORE:  begin mul_a = 34'(am_r[31:0]);    mul_b = 34'(dm); end
      S_M1:    begin mul_a = 34'(am_r[63:32]);   mul_b = 34'(dm); end
      S_M3:    begin mul_a = 34'(x24_r);         mul_b = 34'(lgpc_pkg::LOG2E_Q30); end
      S_M4:    begin mul_a = 34'(prod_r[53:22]); mul_b = 34'(lgpc_pkg::LN2_Q32); end
      S_H1:    begin mul_a = 34'(acc_r);         mul_b = 34'(u_r); end
      S_H2:    begin mul_a = 34'(prod_r[63:32]); mul_b = lgpc_pkg::recip(k_r); end
      S_EM:    begin mul_a = xpos_r ? 34'(p) : 34'(b); mul_b = 34'(ex_r); end
      S_DM:    begin mul_a = 34'(vm);            mul_b = 34'(ex_r); end
      default: begin mul_a = '0;                 mul_b = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= 68'(mul_a) * 68'(mul_b);
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = 64'd1;
    case (state_r)
      S_DIVA: begin
        div_start = 1'b1;
        div_dvd   = {vm, 32'd0};
        div_dvs   = prod_r[63:0];
      end
      S_VS: begin
        div_start = 1'b1;
        div_dvd   = 64'(num_r) << FRAC_BITS;
        div_dvs   = 64'(den_r);
      end
      S_DS1: begin
        div_start = 1'b1;
        div_dvd   = prod_r[63:0];
        div_dvs   = 64'(den_r);
      end
      S_DT: begin
        // second pass over den: integer part and remainder of t / den
        div_start = 1'b1;
        div_dvd   = div_quot;
        div_dvs   = 64'(den_r);
      end
      S_DS2: begin
        div_start = 1'b1;
        div_dvd   = {div_rem[31:0], 32'd0};
        div_dvs   = 64'(den_r);
      end
      S_QS: begin
        div_start = 1'b1;
        div_dvd   = 64'(wm) << FRAC_BITS;
        div_dvs   = 64'(dmag_r);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  lgpc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (!q_empty) state_nxt = q_data.early_err ? S_FIN : S_QI;
      S_QI:    state_nxt = S_DIVA;
      S_DIVA:  state_nxt = S_DIVAW;
      S_DIVAW: if (div_done) state_nxt = S_CORE;
      S_CORE:  state_nxt = S_M1;
      S_M1:    state_nxt = S_M2;
      S_M2:    state_nxt = S_M3;
      S_M3:    state_nxt = S_M4;
      S_M4:    state_nxt = S_M5;
      S_M5:    state_nxt = S_H1;
      S_H1:    state_nxt = S_H2;
      S_H2:    state_nxt = S_H3;
      S_H3:    state_nxt = (k_r == 4'd1) ? S_EX : S_H1;
      S_EX:    state_nxt = S_EM;
      S_EM:    state_nxt = S_DEN;
      S_DEN:   state_nxt = is_deriv ? S_DM : S_VS;
      S_VS:    state_nxt = S_VW;
      S_VW:    if (div_done) state_nxt = S_FIN;
      S_DM:    state_nxt = S_DS1;
      S_DS1:   state_nxt = S_DW1;
      S_DW1:   if (div_done) state_nxt = S_DT;
      S_DT:    state_nxt = S_DTW;
      S_DTW:   if (div_done) state_nxt = (div_quot != '0) ? S_DD : S_DS2;
      S_DS2:   state_nxt = S_DW2;
      S_DW2:   if (div_done) state_nxt = S_DD;
      S_DD: begin
        if (ent_r.item.func == lgpc_pkg::FUNC_DERIV) state_nxt = S_FIN;
        else if (dsat == '0)                         state_nxt = S_CSUM;
        else                                         state_nxt = S_QS;
      end
      S_QS:    state_nxt = S_QW;
      S_QW:    if (div_done) state_nxt = S_CSUM;
      S_CSUM:  state_nxt = S_CORE;
      S_FIN:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= state_r == S_FIN;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        ent_r   <= q_data;
        dt_r    <= q_data.dt0;
        err_r   <= q_data.early_err;
        val_r   <= '0;
        phase_r <= 1'b0;
      end
      S_DIVAW: if (div_done) am_r <= div_quot;
      S_M1:    lo_r <= prod_r[64:0];
      S_M2:    x24_r <= 30'((xm << (38 - FRAC_BITS)) >> 14);
      S_M4:    n_r <= prod_r[60:54];
      S_M5: begin
        u_r   <= prod_r[63:32];
        acc_r <= ONE_Q32;
        k_r   <= lgpc_pkg::EXP_TERMS;
      end
      S_H2:    a_r <= prod_r[63:32];
      S_H3: begin
        acc_r <= ONE_Q32 - 33'(qh);
        k_r   <= k_r - 4'd1;
      end
      S_EX: begin
        ex_r   <= (n_r >= 7'd33) ? 33'd0 : (acc_r >> n_r);
        xpos_r <= (am_r != '0) && (dm != '0) && (vneg != dtneg);
      end
      S_DEN: begin
        if (xpos_r) begin
          den_r <= 34'(pe) + 34'({b, 16'd0});
          num_r <= pe[31:0];
        end else begin
          den_r <= 34'({p, 16'd0}) + 34'(pe);
          num_r <= {p, 16'd0};
        end
      end
      S_VW:    if (div_done) val_r <= div_quot[31:0];
      S_DTW:   if (div_done && div_quot != '0) m_r <= '1;
      S_DW2:   if (div_done) m_r <= div_quot;
      S_DD: begin
        if (dovf) err_r <= 1'b1;
        val_r  <= vneg ? 32'(-dsat) : dsat;
        dmag_r <= dsat;
        dneg_r <= vneg && (dsat != '0);
        if ((dsat == '0) && (ent_r.item.func != lgpc_pkg::FUNC_DERIV)) begin
          // zero derivative: quotient pinned by sign of the shift
          err_r <= 1'b1;
          quo_r <= wneg ? -33'sd2147483648 : 33'sd2147483647;
        end
      end
      S_QW: begin
        if (div_done) begin
          if (qovf) err_r <= 1'b1;
          quo_r <= qneg ? -33'(qsat) : 33'(qsat);
        end
      end
      S_CSUM: begin
        if (covf) err_r <= 1'b1;
        dt_r    <= 33'(c32) - 33'(ent_r.item.t_ref);
        phase_r <= 1'b1;
      end
      S_FIN: begin
        out_data_r.value    <= val_r;
        out_data_r.error    <= err_r;
        out_data_r.last_out <= ent_r.item.last_dim;
      end
      default: begin
        val_r <= val_r;
      end
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/logistic_geodesic_parallel_curve_top.sv
// Logistic curve evaluator, one dimension per request. Requests are taken
// into a 4-deep queue whenever busy is low, so up to four wait while one is
// evaluated. Each request (curve value, derivative or parallel coordinate) is
// then computed on the single shared radix-2 divider and the one shared
// multiplier, which also runs the 12-term exp series. Results come out in
// request order, each as a one-cycle out_valid strobe that the receiver
// must take: there is no back-pressure on the result side.
module logistic_geodesic_parallel_curve_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  lgpc_pkg::in_item_t  in_data,
  output logic                out_valid,
  output lgpc_pkg::out_item_t out_data
);

  lgpc_pkg::q_entry_t push_entry;
  lgpc_pkg::q_entry_t pop_entry;
  logic push, pop, q_full, q_empty;
  logic [lgpc_pkg::QCNT_W-1:0] q_cnt;

  lgpc_front u_front (
    .start   (start),
    .in_data (in_data),
    .q_full  (q_full),
    .busy    (busy),
    .push    (push),
    .entry   (push_entry)
  );

  lgpc_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (push_entry),
    .pop   (pop),
    .rdata (pop_entry),
    .full  (q_full),
    .empty (q_empty),
    .count (q_cnt)
  );

  lgpc_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_data    (pop_entry),
    .q_pop     (pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_accept_queued: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (q_cnt != '0))
    else $error("accepted request not in queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (q_cnt == '0) |-> !pop)
    else $error("pop from empty queue");

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 600;
  localparam int RAND_ITEMS = 1030;
  localparam longint unsigned ONE_Q32 = 64'h1_0000_0000;
  localparam longint unsigned U64_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam longint unsigned POS_LIM = 64'h7FFF_FFFF;
  localparam longint unsigned NEG_LIM = 64'h8000_0000;
  localparam int FB = 16;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  lgpc_pkg::in_item_t in_data;
  logic out_valid;
  lgpc_pkg::out_item_t out_data;

  logistic_geodesic_parallel_curve_top #(.FRAC_BITS(FB)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  always begin
    clk = 1'b0; #5;
    clk = 1'b1; #5;
  end

  lgpc_pkg::out_item_t expected_q[$];
  int errors = 0;
  int accepted = 0;
  int checked = 0;
  int err_results = 0;
  int cycles = 0;
  int func_cnt[4];
  bit use_typed = 1'b0;
  lgpc_pkg::out_item_t typed_result;

  function automatic longint unsigned mag64(longint v);
    return v < 0 ? longint'(0) - v : v;
  endfunction

  function automatic longint clamp_signed(bit neg, longint unsigned m, inout bit err);
    if (neg) begin
      if (m > NEG_LIM) begin err = 1'b1; m = NEG_LIM; end
      return -longint'(m);
    end
    if (m > POS_LIM) begin err = 1'b1; m = POS_LIM; end
    return longint'(m);
  endfunction

  // exp(-|x|) in Q0.32, sign of x, and the Q0.32 denominator
  function automatic void logistic_core(input longint unsigned p, input longint v,
                                        input longint dt,
                                        output longint unsigned ex, output bit xpos,
                                        output longint unsigned den);
    longint unsigned qi, vm, dm, am, cap, xm, x24, y, n, f, u, acc, b;
    qi = p * (65536 - p);
    vm = mag64(v);
    dm = mag64(dt);
    am = (vm << 32) / qi;
    cap = longint'(32) << FB;
    b = 65536 - p;
    if (dm != 0 && am > U64_MAX / dm) xm = cap;
    else xm = (am * dm) >> FB;
    if (xm > cap) xm = cap;
    x24 = (xm << (38 - FB)) >> 14;
    y = x24 * longint'(lgpc_pkg::LOG2E_Q30);
    n = y >> 54;
    f = (y >> 22) & 64'hFFFF_FFFF;
    u = (f * longint'(lgpc_pkg::LN2_Q32)) >> 32;
    acc = ONE_Q32;
    for (int k = 12; k >= 1; k--)
      acc = ONE_Q32 - ((acc * u) >> 32) / longint'(k);
    ex = n >= 33 ? 0 : acc >> n;
    xpos = am != 0 && dm != 0 && ((v < 0) != (dt < 0));
    if (xpos) den = ((p * ex) >> 16) + (b << 16);
    else den = (p << 16) + ((b * ex) >> 16);
  endfunction

  function automatic longint logistic_value(longint unsigned p, longint v, longint dt);
    longint unsigned ex, den, num;
    bit xpos;
    logistic_core(p, v, dt, ex, xpos, den);
    num = xpos ? (p * ex) >> 16 : p << 16;
    return longint'((num << FB) / den);
  endfunction

  function automatic longint logistic_slope(longint unsigned p, longint v, longint dt,
                                            inout bit err);
    longint unsigned ex, den, t, q, r, m;
    bit xpos;
    logistic_core(p, v, dt, ex, xpos, den);
    t = (mag64(v) * ex) / den;
    q = t / den;
    r = t % den;
    m = q != 0 ? U64_MAX : (r << 32) / den;
    return clamp_signed(v < 0, m, err);
  endfunction

  function automatic lgpc_pkg::out_item_t predict_curve(lgpc_pkg::in_item_t it);
    lgpc_pkg::out_item_t res;
    longint unsigned p, qm;
    longint t0, v, t, w, off, val, d, quo, c;
    bit err;
    p = it.p_start;
    t0 = it.t_ref;
    v = it.speed;
    t = it.t_eval;
    w = it.space_shift;
    off = it.time_offset;
    err = 1'b0;
    val = 0;
    if (it.func == lgpc_pkg::FUNC_NONE || p == 0) begin
      err = 1'b1;
    end else if (it.func == lgpc_pkg::FUNC_VALUE) begin
      val = logistic_value(p, v, t - t0);
    end else if (it.func == lgpc_pkg::FUNC_DERIV) begin
      val = logistic_slope(p, v, t - t0, err);
    end else begin
      d = logistic_slope(p, v, off, err);
      if (d == 0) begin
        err = 1'b1;
        quo = w < 0 ? -longint'(NEG_LIM) : longint'(POS_LIM);
      end else begin
        qm = (mag64(w) << FB) / mag64(d);
        quo = clamp_signed((w < 0) != (d < 0), qm, err);
      end
      c = quo + off + t;
      c = clamp_signed(c < 0, mag64(c), err);
      val = logistic_value(p, v, c - t0);
    end
    res.value = val[31:0];
    res.error = err;
    res.last_out = it.last_dim;
    return res;
  endfunction

  // request capture and result check, both on the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && start && !busy) begin
      expected_q.insert(expected_q.size(),
                        use_typed ? typed_result : predict_curve(in_data));
      accepted <= accepted + 1;
      func_cnt[in_data.func] <= func_cnt[in_data.func] + 1;
    end
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result value=%h error=%b last=%b", $time,
                 out_data.value, out_data.error, out_data.last_out);
        errors <= errors + 1;
      end else begin
        if (out_data !== expected_q[0]) begin
          $display("%0t: mismatch expected value=%h error=%b last=%b", $time,
                   expected_q[0].value, expected_q[0].error, expected_q[0].last_out);
          $display("%0t:          actual   value=%h error=%b last=%b", $time,
                   out_data.value, out_data.error, out_data.last_out);
          errors <= errors + 1;
        end
        void'(expected_q.pop_front());
        checked <= checked + 1;
        if (out_data.error) err_results <= err_results + 1;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, expected_q.size());
      $display("testbench failed");
      $finish;
    end
  end

  // directed rows; has_typed marks an expected result read straight off the formulas
  typedef struct {
    lgpc_pkg::in_item_t item;
    bit has_typed;
    lgpc_pkg::out_item_t typed;
  } stim_row_t;

  stim_row_t stim_table[$];

  function automatic lgpc_pkg::in_item_t mk(logic [1:0] fn, logic [15:0] p, int t0, int v,
                                            int t, int w, int off, bit last);
    lgpc_pkg::in_item_t it;
    it.func = fn; it.p_start = p; it.t_ref = t0; it.speed = v; it.t_eval = t;
    it.space_shift = w; it.time_offset = off; it.last_dim = last;
    return it;
  endfunction

  task automatic add_row(lgpc_pkg::in_item_t it, bit typed, int val, bit err);
    stim_row_t r;
    r.item = it;
    r.has_typed = typed;
    r.typed.value = val;
    r.typed.error = err;
    r.typed.last_out = it.last_dim;
    stim_table.insert(stim_table.size(), r);
  endtask

  function automatic int rand_time(bit wide);
    int m;
    if (wide) return int'($urandom);
    m = int'($urandom_range(0, 32'h0008_0000));
    return $urandom_range(0, 1) ? -m : m;
  endfunction

  function automatic lgpc_pkg::in_item_t rand_item(bit last);
    lgpc_pkg::in_item_t it;
    int sel;
    sel = $urandom_range(0, 99);
    it.func = sel < 3 ? lgpc_pkg::FUNC_NONE : 2'($urandom_range(0, 2));
    sel = $urandom_range(0, 99);
    if (sel < 2) it.p_start = 16'd0;
    else if (sel < 6) it.p_start = 16'd1;
    else if (sel < 10) it.p_start = 16'hFFFF;
    else it.p_start = 16'($urandom_range(1, 65535));
    it.t_ref = rand_time($urandom_range(0, 4) == 0);
    it.speed = rand_time($urandom_range(0, 4) == 0);
    it.t_eval = rand_time($urandom_range(0, 4) == 0);
    it.space_shift = rand_time($urandom_range(0, 4) == 0);
    it.time_offset = rand_time($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 19) == 0) it.speed = 0;
    it.last_dim = last;
    return it;
  endfunction

  int idle_pct;

  task automatic send_request(lgpc_pkg::in_item_t it, bit typed, lgpc_pkg::out_item_t tr);
    int prev_cnt;
    if ($urandom_range(1, 100) <= idle_pct) begin
      start = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    in_data = it;
    use_typed = typed;
    typed_result = tr;
    start = 1'b1;
    prev_cnt = accepted;
    do @(negedge clk); while (accepted == prev_cnt);
  endtask

  initial begin
    int mn, mx;
    int dim;
    lgpc_pkg::out_item_t none;
    mn = 32'h8000_0000;
    mx = 32'h7FFF_FFFF;
    none = '0;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    idle_pct = 0;
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // flat curve: value equals p, slope zero
    add_row(mk(lgpc_pkg::FUNC_VALUE, 16'd32768, 0, 0, 65536, 0, 0, 0), 1, 32768, 0);
    add_row(mk(lgpc_pkg::FUNC_VALUE, 16'd1, 0, 0, mx, 0, 0, 1), 1, 1, 0);
    add_row(mk(lgpc_pkg::FUNC_VALUE, 16'hFFFF, mn, 0, mx, 0, 0, 0), 1, 65535, 0);
    add_row(mk(lgpc_pkg::FUNC_DERIV, 16'd12345, mn, 0, mx, 0, 0, 1), 1, 0, 0);
    // unused selector and zero p
    add_row(mk(lgpc_pkg::FUNC_NONE, 16'd30000, 5, 65536, 7, 9, 11, 1), 1, 0, 1);
    add_row(mk(lgpc_pkg::FUNC_VALUE, 16'd0, 0, 65536, 65536, 0, 0, 0), 1, 0, 1);
    add_row(mk(lgpc_pkg::FUNC_PAR, 16'd0, mx, mn, mx, mn, mx, 1), 1, 0, 1);
    // zero slope in the parallel coordinate, both signs of the shift and a zero shift
    add_row(mk(lgpc_pkg::FUNC_PAR, 16'd20000, 0, 0, 0, 65536, 0, 0), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_PAR, 16'd20000, 0, 0, 0, -65536, 0, 0), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_PAR, 16'd20000, 0, 0, 0, 0, 0, 1), 0, 0, 0);
    // extremes of times and slopes
    add_row(mk(lgpc_pkg::FUNC_VALUE, 16'd32768, mn, mx, mx, 0, 0, 0), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_VALUE, 16'd32768, mx, mx, mn, 0, 0, 1), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_DERIV, 16'd1, 0, mx, 0, 0, 0, 0), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_DERIV, 16'hFFFF, 0, mn, 0, 0, 0, 1), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_DERIV, 16'd32768, 0, 65536, 65536, 0, 0, 0), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_DERIV, 16'd40000, mn, mn, mx, 0, 0, 0), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_PAR, 16'd32768, 0, 65536, 65536, 65536, 65536, 1), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_PAR, 16'd1, mn, mx, mx, mx, mx, 0), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_PAR, 16'hFFFF, mx, mn, mn, mn, mn, 1), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_PAR, 16'd50000, 100, -3000, 200, mx, -70000, 0), 0, 0, 0);
    add_row(mk(lgpc_pkg::FUNC_VALUE, 16'h5555, 32'h5555_5555, 32'h2AAA_AAAA, 32'hAAAA_AAAA,
               0, 0, 1), 0, 0, 0);

    foreach (stim_table[i]) send_request(stim_table[i].item, stim_table[i].has_typed,
                                         stim_table[i].typed);
    start = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);

    dim = 0;
    for (int i = 0; i < RAND_ITEMS; i++) begin
      case ((i * 4) / RAND_ITEMS)
        0: idle_pct = 0;
        1: idle_pct = 82;
        2: idle_pct = 0;
        default: idle_pct = 22;
      endcase
      if (i == RAND_ITEMS / 2) begin
        start = 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
      end
      dim = dim + 1;
      if ($urandom_range(0, 3) == 0) dim = 0;
      send_request(rand_item(dim == 0), 1'b0, none);
    end
    start = 1'b0;
    while (expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("%0d requests (value %0d, slope %0d, parallel %0d, unused %0d)",
             accepted, func_cnt[0], func_cnt[1], func_cnt[2], func_cnt[3]);
    $display("%0d results checked, %0d flagged an error, %0d mismatches",
             checked, err_results, errors);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
